[hdl/rgps_pkg.sv]
// Shared types and constants for the gate pattern sequencer.
// No dependencies; imported by every module in the block.
`timescale 1ns / 1ps

package rgps_pkg;

	localparam int PHASE_W   = 32;
	localparam int PW_W      = 16;
	localparam int LEN_W     = 5;
	localparam int NOTES_W   = 48;
	localparam int NOTE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOTES       = 2'd3;

	localparam logic [PHASE_W-1:0] RST_PHASE_INC   = 32'd8947849;
	localparam logic [PW_W-1:0]    RST_PULSE_WIDTH = 16'd32768;
	localparam logic [LEN_W-1:0]   RST_PATTERN_LEN = 5'd16;
	localparam logic [NOTES_W-1:0] RST_NOTES       = 48'd40210710958665;

	localparam logic [1:0] DUR_SIXTEENTH = 2'd0;
	localparam logic [1:0] DUR_EIGHTH    = 2'd1;

	localparam logic [2:0] QUAD_NONE = 3'd4;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_increment;
		logic [PW_W-1:0]    pulse_width;
		logic [LEN_W-1:0]   pattern_length;
		logic [NOTES_W-1:0] pattern_notes;
	} rgps_cfg_t;

	typedef struct packed {
		logic gate;
		logic cycle_wrapped;
		logic half_crossed;
	} rgps_result_t;

endpackage

[hdl/rhythmic_gate_pattern_sequencer_unit.sv]
// Top level of the gate pattern sequencer: input register, state, result
// register. Depends on rgps_pkg, rgps_cfg_regs and rgps_step_logic.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per tick: opcode 0
//   advances the bar phase one tick, opcode 1 restarts at restart_phase.
//   Output channel (out_valid/out_stall) returns one beat per input beat
//   with gate, cycle_wrapped and half_crossed, in order.
//   A beat taken into the input register moves into the result register, and
//   onto the output, on an edge at which the pipeline advances.
//   Throughput: one beat per unstalled cycle; the whole tick update (quadrant
//   check, note fetch, 32-bit accumulate and gate compare) is one combinational
//   pass between the input register and the state/result registers.
//   When the receiver stalls with a result waiting, the pipeline holds and
//   in_stall rises in the same cycle; no beat is lost or repeated.
//   Reset (arst_n low) empties both stages, clears phase and step, marks the
//   quadrant as not yet seen and loads the default configuration. The user
//   writes configuration (cfg_we/cfg_index/cfg_data) only while idle; not enforced.

module rhythmic_gate_pattern_sequencer_unit
	import rgps_pkg::*;
#(
	parameter int MAX_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 opcode,
	input  logic [PHASE_W-1:0]   restart_phase,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 gate,
	output logic                 cycle_wrapped,
	output logic                 half_crossed,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int STEP_W = (MAX_STEPS > 4) ? $clog2(MAX_STEPS) : 2;

	rgps_cfg_t          cfg;
	logic               advance;

	logic               valid_s1;
	logic               opcode_s1;
	logic [PHASE_W-1:0] restart_phase_s1;

	logic [PHASE_W-1:0] phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [2:0]         last_quad_q;
	logic               held_active_q;
	logic [1:0]         held_dur_q;

	logic [PHASE_W-1:0] phase_nxt;
	logic [STEP_W-1:0]  step_nxt;
	logic [2:0]         last_quad_nxt;
	logic               held_active_nxt;
	logic [1:0]         held_dur_nxt;
	rgps_result_t       result;

	logic               valid_q;
	rgps_result_t       result_q;

	rgps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rgps_step_logic #(
		.MAX_STEPS (MAX_STEPS),
		.STEP_W    (STEP_W)
	) u_step (
		.cfg             (cfg),
		.opcode          (opcode_s1),
		.restart_phase   (restart_phase_s1),
		.phase           (phase_q),
		.step            (step_q),
		.last_quad       (last_quad_q),
		.held_active     (held_active_q),
		.held_dur        (held_dur_q),
		.phase_nxt       (phase_nxt),
		.step_nxt        (step_nxt),
		.last_quad_nxt   (last_quad_nxt),
		.held_active_nxt (held_active_nxt),
		.held_dur_nxt    (held_dur_nxt),
		.result          (result)
	);

	assign advance  = ~valid_q | ~out_stall;
	assign in_stall = ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			opcode_s1        <= opcode;
			restart_phase_s1 <= restart_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			step_q        <= '0;
			last_quad_q   <= QUAD_NONE;
			held_active_q <= 1'b0;
			held_dur_q    <= '0;
		end else if (advance && valid_s1) begin
			phase_q       <= phase_nxt;
			step_q        <= step_nxt;
			last_quad_q   <= last_quad_nxt;
			held_active_q <= held_active_nxt;
			held_dur_q    <= held_dur_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign out_valid     = valid_q;
	assign gate          = result_q.gate;
	assign cycle_wrapped = result_q.cycle_wrapped;
	assign half_crossed  = result_q.half_crossed;

`ifndef SYNTHESIS
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && opcode_s1 == OP_RESTART |=>
		out_valid && !gate && !cycle_wrapped && !half_crossed)
		else $error("restart beat produced nonzero result");

	a_restart_relatch: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && opcode_s1 == OP_RESTART |=>
		last_quad_q == QUAD_NONE && step_q == '0)
		else $error("restart did not clear step and quadrant");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(STEP_W+1)'(step_q) < (STEP_W+1)'(MAX_STEPS))
		else $error("step index beyond MAX_STEPS");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(step_q) && $stable(result_q))
		else $error("state moved while output stalled");
`endif

endmodule

[hdl/rgps_cfg_regs.sv]
// Configuration register file: four write-only registers.
// Depends on rgps_pkg for widths, indexes and reset values.
`timescale 1ns / 1ps

module rgps_cfg_regs
	import rgps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output rgps_cfg_t            cfg
);

	rgps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_increment <= RST_PHASE_INC;
			cfg_q.pulse_width     <= RST_PULSE_WIDTH;
			cfg_q.pattern_length  <= RST_PATTERN_LEN;
			cfg_q.pattern_notes   <= RST_NOTES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PHASE_INC:   cfg_q.phase_increment <= cfg_data[PHASE_W-1:0];
				REG_PULSE_WIDTH: cfg_q.pulse_width     <= cfg_data[PW_W-1:0];
				REG_PATTERN_LEN: cfg_q.pattern_length  <= cfg_data[LEN_W-1:0];
				REG_NOTES:       cfg_q.pattern_notes   <= cfg_data[NOTES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/rgps_step_logic.sv]
// Per-tick next-state and result logic: restart, quadrant relatch, step
// advance, gate compare and phase accumulate. Depends on rgps_pkg.
`timescale 1ns / 1ps

module rgps_step_logic
	import rgps_pkg::*;
#(
	parameter int MAX_STEPS = 16,
	parameter int STEP_W    = 4
) (
	input  rgps_cfg_t          cfg,
	input  logic               opcode,
	input  logic [PHASE_W-1:0] restart_phase,
	input  logic [PHASE_W-1:0] phase,
	input  logic [STEP_W-1:0]  step,
	input  logic [2:0]         last_quad,
	input  logic               held_active,
	input  logic [1:0]         held_dur,
	output logic [PHASE_W-1:0] phase_nxt,
	output logic [STEP_W-1:0]  step_nxt,
	output logic [2:0]         last_quad_nxt,
	output logic               held_active_nxt,
	output logic [1:0]         held_dur_nxt,
	output rgps_result_t       result
);

	localparam logic [LEN_W:0] MAX_LIMIT = (LEN_W+1)'(MAX_STEPS);

	logic [1:0]         quad;
	logic               relatch;
	logic [NOTE_W-1:0]  note;
	logic [5:0]         note_bit;
	logic [LEN_W:0]     limit;
	logic [LEN_W:0]     step_inc;
	logic [STEP_W-1:0]  step_adv;
	logic               do_adv;
	logic               act;
	logic [1:0]         dur;
	logic               below;
	logic [PHASE_W:0]   sum;
	logic [PHASE_W:0]   diff;

	assign quad     = phase[PHASE_W-1 -: 2];
	assign relatch  = ({1'b0, quad} != last_quad);
	assign note_bit = 6'(step) * 6'(NOTE_W);
	assign note     = cfg.pattern_notes[note_bit +: NOTE_W];

	assign limit    = ({1'b0, cfg.pattern_length} > MAX_LIMIT) ? MAX_LIMIT
	                                                            : {1'b0, cfg.pattern_length};
	assign step_inc = (LEN_W+1)'(step) + 1'b1;
	assign step_adv = (step_inc >= limit) ? '0 : step_inc[STEP_W-1:0];

	assign act = relatch ? note[0] : held_active;
	assign dur = relatch ? note[2:1] : held_dur;

	always_comb begin
		case (dur)
			DUR_SIXTEENTH: do_adv = 1'b1;
			DUR_EIGHTH:    do_adv = quad[0];
			default:       do_adv = (quad == 2'd3);
		endcase
	end

	always_comb begin
		case (dur)
			DUR_SIXTEENTH: below = phase[29:0] < {cfg.pulse_width, 14'b0};
			DUR_EIGHTH:    below = phase[30:0] < {cfg.pulse_width, 15'b0};
			default:       below = phase < {cfg.pulse_width, 16'b0};
		endcase
	end

	assign sum  = {1'b0, phase} + {1'b0, cfg.phase_increment};
	assign diff = {1'b0, sum[PHASE_W-1:0]} - {1'b0, cfg.phase_increment};

	always_comb begin
		if (opcode == OP_RESTART) begin
			phase_nxt       = restart_phase;
			step_nxt        = '0;
			last_quad_nxt   = QUAD_NONE;
			held_active_nxt = held_active;
			held_dur_nxt    = held_dur;
			result          = '0;
		end else begin
			phase_nxt            = sum[PHASE_W-1:0];
			step_nxt             = (relatch && do_adv) ? step_adv : step;
			last_quad_nxt        = {1'b0, quad};
			held_active_nxt      = act;
			held_dur_nxt         = dur;
			result.gate          = act & below;
			result.cycle_wrapped = sum[PHASE_W];
			// borrow means new phase minus increment went negative, so below half
			result.half_crossed  = sum[PHASE_W-1] & (diff[PHASE_W] | ~diff[PHASE_W-1]);
		end
	end

endmodule
